[design/ptwd_pkg.sv]
// Package for the packed text word decoder.
// Holds code values, the special character table and the shared struct types.
// No dependencies.
package ptwd_pkg;

  localparam int unsigned CODE_W  = 5;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned COUNT_W = 2;
  localparam int unsigned ALPHA_W = 2;
  localparam int unsigned LANES   = 3;
  localparam int unsigned END_BIT = 15;

  // Code values
  localparam logic [CODE_W-1:0] CODE_SPACE      = 5'd0;
  localparam logic [CODE_W-1:0] CODE_NEWLINE    = 5'd1;
  localparam logic [CODE_W-1:0] CODE_SHIFT_UP   = 5'd2;
  localparam logic [CODE_W-1:0] CODE_SHIFT_SPEC = 5'd3;
  localparam logic [CODE_W-1:0] CODE_LOCK_UP    = 5'd4;
  localparam logic [CODE_W-1:0] CODE_LOCK_SPEC  = 5'd5;

  // Alphabet identifiers
  localparam logic [ALPHA_W-1:0] ALPHA_LOWER = 2'd0;
  localparam logic [ALPHA_W-1:0] ALPHA_UPPER = 2'd1;
  localparam logic [ALPHA_W-1:0] ALPHA_SPEC  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_SPACE   = 7'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 7'h0A;
  // Letter codes start at 6: offsets fold that in
  localparam logic [CHAR_W-1:0] LOWER_OFS  = 7'd91;  // 'a' - 6
  localparam logic [CHAR_W-1:0] UPPER_OFS  = 7'd59;  // 'A' - 6

  // Special alphabet, indexed by code; the last two entries, codes 30 and 31, give '?'
  localparam logic [CHAR_W-1:0] SPECIAL_TBL [0:31] = '{
    7'h20, 7'h0A, 7'h20, 7'h20, 7'h20, 7'h20,
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
    7'h2E, 7'h2C, 7'h21, 7'h3F, 7'h5F, 7'h23, 7'h27, 7'h22, 7'h2F, 7'h5C,
    7'h2D, 7'h3A, 7'h28, 7'h29,
    7'h3F, 7'h3F
  };

  typedef struct packed {
    logic [ALPHA_W-1:0] locked;
    logic               pend;
    logic [ALPHA_W-1:0] shift_alpha;
  } alpha_state_t;

  typedef struct packed {
    logic              emit;
    logic [CHAR_W-1:0] ch;
  } lane_res_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  first_char;
    logic [CHAR_W-1:0]  second_char;
    logic [CHAR_W-1:0]  third_char;
    logic [COUNT_W-1:0] char_count;
    logic               string_end;
  } out_beat_t;

endpackage

[design/ptwd_in_if.sv]
// Input channel: one packed text word per beat.
// Depends on ptwd_pkg.
interface ptwd_in_if;
  import ptwd_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] code_word;

  modport source (output valid, output code_word, input ready);
  modport sink   (input valid, input code_word, output ready);
endinterface

[design/ptwd_out_if.sv]
// Result channel: up to three characters, a count and the end flag per beat.
// Depends on ptwd_pkg.
interface ptwd_out_if;
  import ptwd_pkg::*;

  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  first_char;
  logic [CHAR_W-1:0]  second_char;
  logic [CHAR_W-1:0]  third_char;
  logic [COUNT_W-1:0] char_count;
  logic               string_end;

  modport source (output valid, output first_char, output second_char, output third_char,
                  output char_count, output string_end, input ready);
  modport sink   (input valid, input first_char, input second_char, input third_char,
                  input char_count, input string_end, output ready);
endinterface

[design/ptwd_lane.sv]
// One decode lane: a single 5-bit code against the incoming alphabet state.
// Depends on ptwd_pkg.
module ptwd_lane (
  input  logic [ptwd_pkg::CODE_W-1:0] code,
  input  ptwd_pkg::alpha_state_t      st_in,
  output ptwd_pkg::alpha_state_t      st_out,
  output ptwd_pkg::lane_res_t         res
);
  import ptwd_pkg::*;

  logic [ALPHA_W-1:0] alpha;

  always_comb begin
    st_out = st_in;
    res    = '0;
    alpha  = st_in.pend ? st_in.shift_alpha : st_in.locked;
    case (code)
      CODE_SPACE: begin
        res.emit = 1'b1;
        res.ch   = CH_SPACE;
      end
      CODE_NEWLINE: begin
        res.emit = 1'b1;
        res.ch   = CH_NEWLINE;
      end
      CODE_SHIFT_UP: begin
        st_out.pend        = 1'b1;
        st_out.shift_alpha = ALPHA_UPPER;
      end
      CODE_SHIFT_SPEC: begin
        st_out.pend        = 1'b1;
        st_out.shift_alpha = ALPHA_SPEC;
      end
      CODE_LOCK_UP: begin
        st_out.locked = ALPHA_UPPER;
      end
      CODE_LOCK_SPEC: begin
        st_out.locked = ALPHA_SPEC;
      end
      default: begin
        // letter: clears any pending shift
        st_out.pend = 1'b0;
        res.emit    = 1'b1;
        if (alpha == ALPHA_LOWER) begin
          res.ch = CHAR_W'(code) + LOWER_OFS;
        end else if (alpha == ALPHA_UPPER) begin
          res.ch = CHAR_W'(code) + UPPER_OFS;
        end else begin
          res.ch = SPECIAL_TBL[code];
        end
      end
    endcase
  end
endmodule

[design/ptwd_merge.sv]
// Merge stage: packs the emitting lanes into consecutive character slots.
// Depends on ptwd_pkg.
module ptwd_merge (
  input  ptwd_pkg::lane_res_t res0,
  input  ptwd_pkg::lane_res_t res1,
  input  ptwd_pkg::lane_res_t res2,
  input  logic                end_flag,
  output ptwd_pkg::out_beat_t beat
);
  import ptwd_pkg::*;

  always_comb begin
    beat            = '0;
    beat.string_end = end_flag;
    beat.char_count = COUNT_W'(res0.emit) + COUNT_W'(res1.emit) + COUNT_W'(res2.emit);

    if (res0.emit) begin
      beat.first_char = res0.ch;
    end else if (res1.emit) begin
      beat.first_char = res1.ch;
    end else if (res2.emit) begin
      beat.first_char = res2.ch;
    end

    if (res0.emit && res1.emit) begin
      beat.second_char = res1.ch;
    end else if ((res0.emit || res1.emit) && res2.emit) begin
      beat.second_char = res2.ch;
    end

    if (res0.emit && res1.emit && res2.emit) begin
      beat.third_char = res2.ch;
    end
  end
endmodule

[design/packed_text_word_decoder.sv]
// Packed text word decoder, top level.
// Each accepted word is decoded combinationally; its result beat is registered in
// the output slot, or the skid slot while out_ch stalls. One word per cycle while the
// skid slot is empty; the alphabet state chains through the three lanes and is registered once per word.
// Reset (rst_n low, synchronous): alphabet state to lower case, no shift, both
// output slots empty. A stalled result is held while one more word is taken.
module packed_text_word_decoder (
  input  logic              clk,
  input  logic              rst_n,
  ptwd_in_if.sink           in_ch,
  ptwd_out_if.source        out_ch
);
  import ptwd_pkg::*;

  // Alphabet state carried between words
  alpha_state_t state_r;
  alpha_state_t st0_out;
  alpha_state_t st1_out;
  alpha_state_t st2_out;
  alpha_state_t state_nxt;

  lane_res_t res0;
  lane_res_t res1;
  lane_res_t res2;
  out_beat_t beat_new;

  // Output register plus one skid slot
  logic      out_valid_r;
  out_beat_t out_data_r;
  logic      skid_valid_r;
  out_beat_t skid_data_r;

  logic in_fire;
  logic out_free;

  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Three lanes, high code first; each sees the state left by the one before
  ptwd_lane u_lane0 (
    .code   (in_ch.code_word[14:10]),
    .st_in  (state_r),
    .st_out (st0_out),
    .res    (res0)
  );

  ptwd_lane u_lane1 (
    .code   (in_ch.code_word[9:5]),
    .st_in  (st0_out),
    .st_out (st1_out),
    .res    (res1)
  );

  ptwd_lane u_lane2 (
    .code   (in_ch.code_word[4:0]),
    .st_in  (st1_out),
    .st_out (st2_out),
    .res    (res2)
  );

  ptwd_merge u_merge (
    .res0     (res0),
    .res1     (res1),
    .res2     (res2),
    .end_flag (in_ch.code_word[END_BIT]),
    .beat     (beat_new)
  );

  // End marker drops all alphabet state once the word is decoded
  always_comb begin
    state_nxt = state_r;
    if (in_fire) begin
      state_nxt = in_ch.code_word[END_BIT] ? '0 : st2_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output slot and skid slot; order kept: skid drains before new beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_fire) begin
        out_data_r <= beat_new;
      end
    end else if (in_fire) begin
      skid_data_r <= beat_new;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.first_char  = out_data_r.first_char;
  assign out_ch.second_char = out_data_r.second_char;
  assign out_ch.third_char  = out_data_r.third_char;
  assign out_ch.char_count  = out_data_r.char_count;
  assign out_ch.string_end  = out_data_r.string_end;

`ifndef SYNTH
  // Skid slot only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot full while output slot empty");

  // A word with the end marker leaves lower case, no shift pending
  a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.code_word[END_BIT]) |=> (state_r == '0))
    else $error("alphabet state not cleared after end marker");

  // Empty result carries no characters
  a_empty_no_chars: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.char_count == '0)) |->
      (out_data_r.first_char == '0 && out_data_r.second_char == '0 &&
       out_data_r.third_char == '0))
    else $error("characters present with zero count");
`endif

endmodule
